// ===== design/i2c_master_byte_sequencer_core_assert.svh =====
// Assertion macros used by the sequencer RTL (i2cmbs_seq)
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_ASSERT_SVH

// Checked only outside reset
`define I2CMBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define I2CMBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/i2cmbs_pkg.sv =====
package i2cmbs_pkg;

    // Delay counter width; register values above its maximum saturate
    localparam int DELAY_WIDTH = 16;
    localparam int REG_W       = 16;
    localparam int NUM_REGS    = 7;
    localparam int CFG_IDX_W   = 3;

    localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_WIDTH) - 33'd1;

    typedef logic [DELAY_WIDTH-1:0] t_delay;
    typedef logic [REG_W-1:0]       t_reg;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETUP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STSU  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STHD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPSU  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUF   = 3'd6;

    localparam t_reg REG_RESET [NUM_REGS] = '{
        16'd18, 16'd286, 16'd336, 16'd286, 16'd336, 16'd286, 16'd4358
    };

    // Command codes; codes above OP_READ act as a plain tick
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_S1    = 4'd1,
        PH_S2    = 4'd2,
        PH_S3    = 4'd3,
        PH_S4    = 4'd4,
        PH_S5    = 4'd5,
        PH_P1    = 4'd6,
        PH_P2    = 4'd7,
        PH_P3    = 4'd8,
        PH_P4    = 4'd9,
        PH_BSET  = 4'd10,
        PH_BHIGH = 4'd11,
        PH_BLOW  = 4'd12,
        PH_RREL  = 4'd13,
        PH_RHIGH = 4'd14,
        PH_RLOW  = 4'd15
    } t_phase;

    typedef struct packed {
        t_reg setup;
        t_reg high;
        t_reg stsu;
        t_reg sthd;
        t_reg low;
        t_reg spsu;
        t_reg buf_free;
    } t_timing;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       got_nack;
        logic       rejected;
    } t_result;

    // Step length from a register value: zero counts as one, large values saturate
    function automatic t_delay f_step_len(input t_reg v);
        logic [32:0] w;
        begin
            w = 33'(v);
            if (w > DELAY_MAX) w = DELAY_MAX;
            if (w == 33'd0) w = 33'd1;
            return w[DELAY_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== design/i2cmbs_if.sv =====
// Command beat: one timing tick, optionally carrying a command
interface i2cmbs_cmd_if;
    import i2cmbs_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
    modport source (output valid, op, tx_byte, send_nack, sda_in, input ready);
    modport sink   (input valid, op, tx_byte, send_nack, sda_in, output ready);
endinterface

// Result beat: line drives and status for one tick
interface i2cmbs_res_if;
    import i2cmbs_pkg::*;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       got_nack;
    logic       rejected;
    modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                    got_nack, rejected, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                    got_nack, rejected, output ready);
endinterface

// Register write beat
interface i2cmbs_cfg_if;
    import i2cmbs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [REG_W-1:0]     wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/i2c_master_byte_sequencer_core.sv =====
// I2C master line sequencer. Every command beat is one timing tick and yields
// exactly one result beat with the SCL/SDA drives (1 = released) and status.
// On an idle tick the beat may carry start, stop, write byte or read byte;
// commands on busy ticks are dropped and flagged as rejected. Each bus step
// lasts the number of ticks in its timing register (zero counts as one).
// Throughput is one beat per clock: the sequencer state and the result
// register update in the same cycle a beat is taken, and the next beat is
// accepted whenever the result register is empty or being drained.
// Timing registers are to be written through the config channel while idle; the block does not enforce it.
module i2c_master_byte_sequencer_core
    import i2cmbs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cmbs_cmd_if.sink    i_cmd,
    i2cmbs_cfg_if.sink    i_cfg,
    i2cmbs_res_if.source  o_res
);

    t_timing w_timing;
    t_result w_res;
    t_result r_res;
    logic    r_res_valid;
    logic    w_step;

    // Input taken when the result slot is free or drains this cycle
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign w_step      = i_cmd.valid && i_cmd.ready;

    i2cmbs_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_timing (w_timing)
    );

    i2cmbs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_op        (i_cmd.op),
        .i_tx_byte   (i_cmd.tx_byte),
        .i_send_nack (i_cmd.send_nack),
        .i_sda_in    (i_cmd.sda_in),
        .i_timing    (w_timing),
        .o_res       (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_step) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) r_res <= w_res;
    end

    assign o_res.valid     = r_res_valid;
    assign o_res.scl_level = r_res.scl_level;
    assign o_res.sda_level = r_res.sda_level;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.rx_byte   = r_res.rx_byte;
    assign o_res.got_nack  = r_res.got_nack;
    assign o_res.rejected  = r_res.rejected;

endmodule

// ===== design/i2cmbs_cfg.sv =====
module i2cmbs_cfg
    import i2cmbs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cmbs_cfg_if.sink   i_cfg,
    output t_timing      o_timing
);

    t_reg r_regs [NUM_REGS];

    // Writes are always taken; indexes past the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= REG_RESET[i];
        end else if (i_cfg.valid && (i_cfg.reg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_regs[i_cfg.reg_index] <= i_cfg.wdata;
        end
    end

    assign o_timing.setup    = r_regs[REG_SETUP];
    assign o_timing.high     = r_regs[REG_HIGH];
    assign o_timing.stsu     = r_regs[REG_STSU];
    assign o_timing.sthd     = r_regs[REG_STHD];
    assign o_timing.low      = r_regs[REG_LOW];
    assign o_timing.spsu     = r_regs[REG_SPSU];
    assign o_timing.buf_free = r_regs[REG_BUF];

endmodule

// ===== design/i2cmbs_seq.sv =====
module i2cmbs_seq
    import i2cmbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_nack,
    input  logic       i_sda_in,
    input  t_timing    i_timing,
    output t_result    o_res
);

    `include "i2c_master_byte_sequencer_core_assert.svh"

    t_phase     r_phase,  n_phase;
    logic [2:0] r_cmd,    n_cmd;
    t_delay     r_delay,  n_delay;
    logic [3:0] r_bit,    n_bit;
    logic [7:0] r_shift,  n_shift;
    logic       r_scl,    n_scl;
    logic       r_sda,    n_sda;
    logic       r_nack,   n_nack;
    logic       r_mnack,  n_mnack;
    logic [7:0] r_rx,     n_rx;
    logic       w_done;
    logic       w_rej;
    logic       w_is_cmd;
    logic [3:0] w_bit_inc;
    logic [7:0] w_shift_sl;

    assign w_is_cmd   = (i_op == OP_START) || (i_op == OP_STOP) ||
                        (i_op == OP_WRITE) || (i_op == OP_READ);
    assign w_bit_inc  = r_bit + 4'd1;
    assign w_shift_sl = {r_shift[6:0], 1'b0};

    // Next state for one tick
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_delay = r_delay;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_nack  = r_nack;
        n_mnack = r_mnack;
        n_rx    = r_rx;
        w_done  = 1'b0;
        w_rej   = 1'b0;

        if (r_phase != PH_IDLE) begin
            w_rej = w_is_cmd;
            if (r_delay > t_delay'(1)) begin
                n_delay = r_delay - t_delay'(1);
            end else begin
                unique case (r_phase)
                    PH_S1: begin
                        n_scl = 1'b1; n_phase = PH_S2; n_delay = f_step_len(i_timing.high);
                    end
                    PH_S2: begin
                        n_scl = 1'b1; n_phase = PH_S3; n_delay = f_step_len(i_timing.stsu);
                    end
                    PH_S3: begin
                        n_sda = 1'b0; n_phase = PH_S4; n_delay = f_step_len(i_timing.sthd);
                    end
                    PH_S4: begin
                        n_scl = 1'b0; n_phase = PH_S5; n_delay = f_step_len(i_timing.low);
                    end
                    PH_P1: begin
                        n_sda = 1'b0; n_phase = PH_P2; n_delay = f_step_len(i_timing.setup);
                    end
                    PH_P2: begin
                        n_scl = 1'b1; n_phase = PH_P3; n_delay = f_step_len(i_timing.spsu);
                    end
                    PH_P3: begin
                        n_sda = 1'b1; n_phase = PH_P4;
                        n_delay = f_step_len(i_timing.buf_free);
                    end
                    PH_BSET: begin
                        n_scl = 1'b1; n_phase = PH_BHIGH; n_delay = f_step_len(i_timing.high);
                    end
                    PH_BHIGH: begin
                        // ACK slot of a write: sample the slave answer
                        if (r_cmd == OP_WRITE && r_bit == 4'd8) n_nack = i_sda_in;
                        n_scl = 1'b0; n_phase = PH_BLOW; n_delay = f_step_len(i_timing.low);
                    end
                    PH_BLOW: begin
                        n_bit   = w_bit_inc;
                        n_shift = w_shift_sl;
                        if (r_cmd == OP_WRITE && w_bit_inc < 4'd8) begin
                            n_sda = w_shift_sl[7];
                            n_phase = PH_BSET; n_delay = f_step_len(i_timing.setup);
                        end else if (r_cmd == OP_WRITE && w_bit_inc == 4'd8) begin
                            n_sda = 1'b1;
                            n_phase = PH_BSET; n_delay = f_step_len(i_timing.setup);
                        end else begin
                            n_phase = PH_IDLE; n_delay = '0; w_done = 1'b1;
                        end
                    end
                    PH_RREL: begin
                        n_scl = 1'b1; n_phase = PH_RHIGH; n_delay = f_step_len(i_timing.high);
                    end
                    PH_RHIGH: begin
                        n_shift = {r_shift[6:0], i_sda_in};
                        n_scl = 1'b0; n_phase = PH_RLOW; n_delay = f_step_len(i_timing.low);
                    end
                    PH_RLOW: begin
                        if (w_bit_inc < 4'd8) begin
                            n_bit = w_bit_inc;
                            n_scl = 1'b1; n_phase = PH_RHIGH;
                            n_delay = f_step_len(i_timing.high);
                        end else begin
                            // byte complete: answer with the held ACK/NACK bit
                            n_bit = 4'd8;
                            n_rx  = r_shift;
                            n_sda = r_mnack;
                            n_phase = PH_BSET; n_delay = f_step_len(i_timing.setup);
                        end
                    end
                    PH_S5, PH_P4: begin
                        n_phase = PH_IDLE; n_delay = '0; w_done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE; n_delay = '0;
                    end
                endcase
            end
        end else if (w_is_cmd) begin
            n_cmd = i_op;
            n_bit = 4'd0;
            case (i_op)
                OP_START: begin
                    n_sda = 1'b1; n_phase = PH_S1; n_delay = f_step_len(i_timing.setup);
                end
                OP_STOP: begin
                    n_scl = 1'b0; n_phase = PH_P1; n_delay = f_step_len(i_timing.low);
                end
                OP_WRITE: begin
                    n_shift = i_tx_byte;
                    n_sda   = i_tx_byte[7];
                    n_phase = PH_BSET; n_delay = f_step_len(i_timing.setup);
                end
                default: begin
                    n_shift = 8'd0;
                    n_mnack = i_send_nack;
                    n_sda   = 1'b1;
                    n_phase = PH_RREL; n_delay = f_step_len(i_timing.setup);
                end
            endcase
        end
    end

    // Result of this tick
    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = w_done;
        o_res.rx_byte   = n_rx;
        o_res.got_nack  = n_nack;
        o_res.rejected  = w_rej;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= OP_TICK;
            r_delay <= '0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_nack  <= 1'b0;
            r_mnack <= 1'b0;
            r_rx    <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_delay <= n_delay;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
            r_mnack <= n_mnack;
            r_rx    <= n_rx;
        end
    end

    `I2CMBS_ASSERT(a_idle_no_count, (r_phase == PH_IDLE) |-> (r_delay == '0), "idle with a running delay")
    `I2CMBS_ASSERT(a_busy_count, (r_phase != PH_IDLE) |-> (r_delay != '0), "busy with an empty delay")
    `I2CMBS_ASSERT(a_bit_range, r_bit <= 4'd9, "bit index out of range")
    `I2CMBS_ASSERT(a_cmd_starts, (i_step && r_phase == PH_IDLE && w_is_cmd) |=> (r_phase != PH_IDLE), "command did not start")
    `I2CMBS_ASSERT(a_done_idle, (i_step && w_done) |=> (r_phase == PH_IDLE), "done without return to idle")

endmodule

// ===== tb/tb_i2c_master_byte_sequencer_core.sv =====
module tb_i2c_master_byte_sequencer_core;
    import i2cmbs_pkg::*;

    // Register index outside the timing set, and op codes that act as plain ticks
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int MAX_PRINTS = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cmbs_cmd_if cmd_if ();
    i2cmbs_cfg_if cfg_if ();
    i2cmbs_res_if res_if ();

    i2c_master_byte_sequencer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sequencer mirror: bus step, wait count, shift register and line drives
    t_phase     seq_phase = PH_IDLE;
    logic [2:0] seq_cmd   = OP_TICK;
    t_delay     seq_wait  = '0;
    logic [3:0] seq_bit   = '0;
    logic [7:0] seq_shift = '0;
    logic       seq_scl   = 1'b1;
    logic       seq_sda   = 1'b1;
    logic       seq_nack  = 1'b0;
    logic       seq_ans   = 1'b0;
    logic [7:0] seq_rx    = '0;
    t_reg       seq_timing [NUM_REGS];

    t_result pending_lines [$];
    t_result head;
    int      mismatch_count = 0;
    bit      quiet = 1'b0;
    int      stall_len;

    // Enter a bus step; a zero register counts as one tick, a long one saturates
    function automatic void enter_step(input t_phase p, input logic [CFG_IDX_W-1:0] idx);
        seq_phase = p;
        if (seq_timing[idx] == '0)
            seq_wait = t_delay'(1);
        else if (33'(seq_timing[idx]) > DELAY_MAX)
            seq_wait = t_delay'(DELAY_MAX);
        else
            seq_wait = t_delay'(seq_timing[idx]);
    endfunction

    // One timing tick of the sequencer; returns the line and status beat it yields
    function automatic t_result sequence_tick(input logic [2:0] op, input logic [7:0] tx,
                                              input logic sn, input logic sd);
        t_result r;
        logic    is_cmd;
        logic    done;
        logic    rej;
        is_cmd = (op >= OP_START) && (op <= OP_READ);
        done   = 1'b0;
        rej    = 1'b0;
        if (seq_phase != PH_IDLE) begin
            rej = is_cmd;
            if (seq_wait > t_delay'(1)) begin
                seq_wait = seq_wait - t_delay'(1);
            end else begin
                case (seq_phase)
                    PH_S1: begin seq_scl = 1'b1; enter_step(PH_S2, REG_HIGH); end
                    PH_S2: begin seq_scl = 1'b1; enter_step(PH_S3, REG_STSU); end
                    PH_S3: begin seq_sda = 1'b0; enter_step(PH_S4, REG_STHD); end
                    PH_S4: begin seq_scl = 1'b0; enter_step(PH_S5, REG_LOW); end
                    PH_P1: begin seq_sda = 1'b0; enter_step(PH_P2, REG_SETUP); end
                    PH_P2: begin seq_scl = 1'b1; enter_step(PH_P3, REG_SPSU); end
                    PH_P3: begin seq_sda = 1'b1; enter_step(PH_P4, REG_BUF); end
                    PH_S5, PH_P4: begin
                        seq_phase = PH_IDLE;
                        seq_wait  = '0;
                        done      = 1'b1;
                    end
                    PH_BSET: begin seq_scl = 1'b1; enter_step(PH_BHIGH, REG_HIGH); end
                    PH_BHIGH: begin
                        // slave ACK is sampled in the ACK slot of a write (bit index 8)
                        if (seq_cmd == OP_WRITE && seq_bit == 4'd8) seq_nack = sd;
                        seq_scl = 1'b0;
                        enter_step(PH_BLOW, REG_LOW);
                    end
                    PH_BLOW: begin
                        seq_bit   = seq_bit + 4'd1;
                        seq_shift = seq_shift << 1;
                        if (seq_cmd == OP_WRITE && seq_bit < 4'd8) begin
                            seq_sda = seq_shift[7];
                            enter_step(PH_BSET, REG_SETUP);
                        end else if (seq_cmd == OP_WRITE && seq_bit == 4'd8) begin
                            seq_sda = 1'b1;
                            enter_step(PH_BSET, REG_SETUP);
                        end else begin
                            seq_phase = PH_IDLE;
                            seq_wait  = '0;
                            done      = 1'b1;
                        end
                    end
                    PH_RREL: begin seq_scl = 1'b1; enter_step(PH_RHIGH, REG_HIGH); end
                    PH_RHIGH: begin
                        seq_shift = {seq_shift[6:0], sd};
                        seq_scl   = 1'b0;
                        enter_step(PH_RLOW, REG_LOW);
                    end
                    PH_RLOW: begin
                        seq_bit = seq_bit + 4'd1;
                        if (seq_bit < 4'd8) begin
                            seq_scl = 1'b1;
                            enter_step(PH_RHIGH, REG_HIGH);
                        end else begin
                            // byte complete: drive the master answer for the ACK slot
                            seq_bit = 4'd8;
                            seq_rx  = seq_shift;
                            seq_sda = seq_ans;
                            enter_step(PH_BSET, REG_SETUP);
                        end
                    end
                    default: begin
                        seq_phase = PH_IDLE;
                        seq_wait  = '0;
                    end
                endcase
            end
        end else if (is_cmd) begin
            seq_cmd = op;
            seq_bit = '0;
            case (op)
                OP_START: begin seq_sda = 1'b1; enter_step(PH_S1, REG_SETUP); end
                OP_STOP:  begin seq_scl = 1'b0; enter_step(PH_P1, REG_LOW); end
                OP_WRITE: begin
                    seq_shift = tx;
                    seq_sda   = tx[7];
                    enter_step(PH_BSET, REG_SETUP);
                end
                default: begin
                    seq_shift = '0;
                    seq_ans   = sn;
                    seq_sda   = 1'b1;
                    enter_step(PH_RREL, REG_SETUP);
                end
            endcase
        end
        r.scl_level = seq_scl;
        r.sda_level = seq_sda;
        r.busy_res  = (seq_phase != PH_IDLE);
        r.done_res  = done;
        r.rx_byte   = seq_rx;
        r.got_nack  = seq_nack;
        r.rejected  = rej;
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        if (quiet) return 0;
        case ($urandom_range(0, 15))
            0:       return $urandom_range(8, 40);
            1, 2, 3: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) flag_mismatch(name, 32'(got), 32'(want));
    endtask

    // Send one tick beat; valid stays high unless a gap comes before the next one
    task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic sn,
                             input logic sd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.op        <= op;
        cmd_if.tx_byte   <= tx;
        cmd_if.send_nack <= sn;
        cmd_if.sda_in    <= sd;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_lines.push_back(sequence_tick(op, tx, sn, sd));
    endtask

    // Issue a command and tick until it finishes; optionally push commands while busy
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic sn,
                           input bit pester);
        logic [2:0] busy_op;
        send_tick(op, tx, sn, 1'($urandom_range(0, 1)));
        while (seq_phase != PH_IDLE) begin
            busy_op = pester ? 3'($urandom_range(OP_START, OP_READ)) : OP_TICK;
            send_tick(busy_op, 8'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Finish the running command, stop sending and wait for every result beat
    task automatic drain_to_idle();
        while (seq_phase != PH_IDLE)
            send_tick(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        cmd_if.valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_reg val);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx < NUM_REGS) seq_timing[idx] = val;
    endtask

    // Load all timing registers once the block is idle; the spare index is ignored
    task automatic load_timing(input t_reg t_setup, input t_reg t_high, input t_reg t_stsu,
                               input t_reg t_sthd, input t_reg t_low, input t_reg t_spsu,
                               input t_reg t_bus);
        drain_to_idle();
        write_reg(REG_SETUP, t_setup);
        write_reg(REG_HIGH, t_high);
        write_reg(REG_STSU, t_stsu);
        write_reg(REG_STHD, t_sthd);
        write_reg(REG_LOW, t_low);
        write_reg(REG_SPSU, t_spsu);
        write_reg(REG_BUF, t_bus);
        write_reg(REG_NONE, t_reg'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    // Start and stop with data setup left at its reset value, other steps one tick
    task automatic test_reset_timing();
        quiet = 1'b1;
        drain_to_idle();
        write_reg(REG_HIGH, 16'd1);
        write_reg(REG_STSU, 16'd1);
        write_reg(REG_STHD, 16'd1);
        write_reg(REG_LOW, 16'd1);
        write_reg(REG_SPSU, 16'd1);
        write_reg(REG_BUF, 16'd1);
        cfg_if.valid <= 1'b0;
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);
        quiet = 1'b0;
    endtask

    // Every command with all steps one tick long (registers written as zero)
    task automatic test_short_steps();
        load_timing('0, '0, '0, '0, '0, '0, '0);
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b1, 1'b0);
        run_cmd(OP_WRITE, 8'h5A, 1'b0, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b0, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b1, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);
        send_tick(OP_TICK, 8'hFF, 1'b1, 1'b1);
        send_tick(OP_SPARE_5, 8'h00, 1'b0, 1'b0);
        send_tick(OP_SPARE_6, 8'hFF, 1'b1, 1'b0);
        send_tick(OP_SPARE_7, 8'h81, 1'b0, 1'b1);
    endtask

    // Commands on every busy tick are rejected, the finishing tick included
    task automatic test_busy_commands();
        load_timing(16'd2, 16'd1, 16'd3, 16'd1, 16'd2, 16'd1, 16'd3);
        run_cmd(OP_START, 8'h00, 1'b0, 1'b1);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, 1'b1);
        run_cmd(OP_READ, 8'h00, 1'b1, 1'b1);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b1);
    endtask

    // Longer start setup and bus free steps
    task automatic test_long_steps();
        load_timing(16'd1, 16'd1, 16'd60, 16'd1, 16'd1, 16'd1, 16'd60);
        quiet = 1'b1;
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b1);
        quiet = 1'b0;
    endtask

    // Random command streams over several short timing sets
    task automatic test_random_traffic();
        int         s;
        int         n;
        int         sel;
        int         top;
        logic [2:0] op;
        for (s = 0; s < 5; s++) begin
            top = (s == 3) ? 12 : 3;
            load_timing(t_reg'($urandom_range(0, top)), t_reg'($urandom_range(0, top)),
                        t_reg'($urandom_range(0, top)), t_reg'($urandom_range(0, top)),
                        t_reg'($urandom_range(0, top)), t_reg'($urandom_range(0, top)),
                        t_reg'($urandom_range(0, top)));
            quiet = (s == 2);
            for (n = 0; n < 50; n++) begin
                sel = $urandom_range(0, 19);
                // idle: mostly a new command; busy: mostly plain ticks, some noise
                if (seq_phase == PH_IDLE)
                    op = (sel < 17) ? 3'($urandom_range(OP_START, OP_READ))
                                    : 3'($urandom_range(0, 7));
                else if (sel < 2)
                    op = 3'($urandom_range(OP_START, OP_READ));
                else if (sel < 4)
                    op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
                else
                    op = OP_TICK;
                send_tick(op, 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            quiet = 1'b0;
        end
    endtask

    // Result side stalls
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall_len = pick_gap();
            if (stall_len == 0) begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // Compare each result beat with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_lines.size() == 0) begin
                flag_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                head = pending_lines.pop_front();
                check_field("scl_level", 8'(res_if.scl_level), 8'(head.scl_level));
                check_field("sda_level", 8'(res_if.sda_level), 8'(head.sda_level));
                check_field("busy_res", 8'(res_if.busy_res), 8'(head.busy_res));
                check_field("done_res", 8'(res_if.done_res), 8'(head.done_res));
                check_field("rx_byte", res_if.rx_byte, head.rx_byte);
                check_field("got_nack", 8'(res_if.got_nack), 8'(head.got_nack));
                check_field("rejected", 8'(res_if.rejected), 8'(head.rejected));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("i2c_master_byte_sequencer_core regression: fail");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.op        = OP_TICK;
        cmd_if.tx_byte   = '0;
        cmd_if.send_nack = 1'b0;
        cmd_if.sda_in    = 1'b1;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = REG_SETUP;
        cfg_if.wdata     = '0;
        foreach (seq_timing[i]) seq_timing[i] = REG_RESET[i];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_timing();
        test_short_steps();
        test_busy_commands();
        test_long_steps();
        test_random_traffic();

        drain_to_idle();
        repeat (8) @(posedge i_clk);
        if (pending_lines.size() != 0)
            flag_mismatch("result beats never came", pending_lines.size(), 0);
        if (mismatch_count == 0) begin
            $display("i2c_master_byte_sequencer_core regression: pass");
        end else begin
            $display("i2c_master_byte_sequencer_core regression: fail");
        end
        $finish;
    end

endmodule
